### rtl/core/btlv_pkg.sv
`default_nettype none

package btlv_pkg;

  // decoding phase, one-hot
  typedef enum logic [5:0] {
    PH_TAG_FIRST = 6'b000001,
    PH_TAG_MORE  = 6'b000010,
    PH_LEN_FIRST = 6'b000100,
    PH_LEN_MORE  = 6'b001000,
    PH_VALUE     = 6'b010000,
    PH_ABSORB    = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TAG   = 2'd0,
    KIND_LEN   = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_DROP  = 2'd3
  } byte_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_TAG_TRUNC     = 3'd1,
    ERR_LEN_MISSING   = 3'd2,
    ERR_LEN_TOO_MANY  = 3'd3,
    ERR_LEN_TRUNC     = 3'd4,
    ERR_VALUE_TRUNC   = 3'd5,
    ERR_TAG_TOO_LONG  = 3'd6
  } error_code_t;

  localparam logic [4:0] TAG_MORE_MASK = 5'h1F;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] tag_acc;
    logic [2:0]  tag_cnt;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [31:0] val_left;
  } state_t;

  typedef struct packed {
    byte_kind_t  byte_kind;
    logic [7:0]  out_byte;
    logic        header_done;
    logic [31:0] tag_value;
    logic [31:0] length_value;
    logic        value_last;
    error_code_t error_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/btlv_if.sv
`default_nettype none

interface btlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;
  modport source (output valid, data_byte, buffer_end, input ready);
  modport sink   (input valid, data_byte, buffer_end, output ready);
endinterface

interface btlv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_kind;
  logic [7:0]  out_byte;
  logic        header_done;
  logic [31:0] tag_value;
  logic [31:0] length_value;
  logic        value_last;
  logic [2:0]  error_code;
  modport source (output valid, byte_kind, out_byte, header_done, tag_value,
                  length_value, value_last, error_code, input ready);
  modport sink   (input valid, byte_kind, out_byte, header_done, tag_value,
                  length_value, value_last, error_code, output ready);
endinterface

interface btlv_cfg_if;
  logic valid;
  logic ready;
  logic single_byte_length;
  modport source (output valid, single_byte_length, input ready);
  modport sink   (input valid, single_byte_length, output ready);
endinterface

`default_nettype wire

### rtl/core/ber_tlv_stream_decoder_core.sv
// streaming ber-tlv header decoder
// in_chan: one buffer byte per item (data_byte) with buffer_end on the
//   buffer's last byte; valid/ready handshake
// out_chan: one result item per input item, in order: byte kind, the byte
//   itself, header_done with tag_value/length_value, value_last, error_code
// cfg_chan: single write-only register single_byte_length, always ready;
//   write it only while no item is in flight
// latency: the result of an item sits in the output register one cycle
//   after it is accepted
// throughput: one item per cycle; the decode state is updated in the same
//   cycle the item is accepted, so consecutive bytes chain with no bubble
// stall: when out_chan.ready is low and the output register is full,
//   in_chan.ready drops; nothing is lost or repeated
// reset (rst_n low, synchronous): decoder waits for the first tag byte,
//   output register empty, single_byte_length cleared
// after an error the remaining bytes up to buffer_end come out as discarded
`default_nettype none

module ber_tlv_stream_decoder_core #(
  parameter int MAX_TAG_BYTES    = 4,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  btlv_in_if.sink     in_chan,
  btlv_out_if.source  out_chan,
  btlv_cfg_if.sink    cfg_chan
);

  // decode state and its next value
  btlv_pkg::state_t  st_r;
  btlv_pkg::state_t  st_nxt;
  btlv_pkg::result_t res;

  logic single_byte_length_r;
  logic space;
  logic accept;

  // config register is always writable
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_byte_length_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      single_byte_length_r <= cfg_chan.single_byte_length;
    end
  end

  // take an item whenever the output register has room for its result
  assign in_chan.ready = space;
  assign accept        = in_chan.valid && space;

  btlv_step #(
    .MAX_TAG_BYTES    (MAX_TAG_BYTES),
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_step (
    .st                 (st_r),
    .data_byte          (in_chan.data_byte),
    .buffer_end         (in_chan.buffer_end),
    .single_byte_length (single_byte_length_r),
    .st_nxt             (st_nxt),
    .res                (res)
  );

  // decode state advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= btlv_pkg::PH_TAG_FIRST;
      st_r.tag_acc  <= '0;
      st_r.tag_cnt  <= '0;
      st_r.len_acc  <= '0;
      st_r.len_left <= '0;
      st_r.val_left <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // result register towards the receiver
  btlv_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .res      (res),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

### rtl/core/btlv_step.sv
`default_nettype none

module btlv_step #(
  parameter int MAX_TAG_BYTES    = 4,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  btlv_pkg::state_t  st,
  input  logic [7:0]        data_byte,
  input  logic              buffer_end,
  input  logic              single_byte_length,
  output btlv_pkg::state_t  st_nxt,
  output btlv_pkg::result_t res
);

  logic        do_fin;
  logic [31:0] fin_len;
  logic [6:0]  n_len;
  logic [31:0] len_shift;
  logic [2:0]  len_left_dec;
  logic [31:0] val_dec;

  assign n_len        = data_byte[6:0];
  assign len_shift    = {st.len_acc[23:0], data_byte};
  assign len_left_dec = st.len_left - 3'd1;
  assign val_dec      = st.val_left - 32'd1;

  always_comb begin
    st_nxt           = st;
    do_fin           = 1'b0;
    fin_len          = '0;
    res.byte_kind    = btlv_pkg::KIND_DROP;
    res.out_byte     = data_byte;
    res.header_done  = 1'b0;
    res.tag_value    = '0;
    res.length_value = '0;
    res.value_last   = 1'b0;
    res.error_code   = btlv_pkg::ERR_NONE;

    unique case (st.phase)
      btlv_pkg::PH_TAG_FIRST: begin
        res.byte_kind  = btlv_pkg::KIND_TAG;
        st_nxt.tag_acc = {24'd0, data_byte};
        st_nxt.tag_cnt = 3'd1;
        if (data_byte[4:0] == btlv_pkg::TAG_MORE_MASK) begin
          st_nxt.phase = btlv_pkg::PH_TAG_MORE;
          if (buffer_end) begin
            res.error_code = btlv_pkg::ERR_TAG_TRUNC;
            st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
          end
        end else begin
          st_nxt.phase = btlv_pkg::PH_LEN_FIRST;
          if (buffer_end) begin
            res.error_code = btlv_pkg::ERR_LEN_MISSING;
            st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
          end
        end
      end
      btlv_pkg::PH_TAG_MORE: begin
        res.byte_kind = btlv_pkg::KIND_TAG;
        if (st.tag_cnt >= 3'(MAX_TAG_BYTES)) begin
          // byte not folded in, tag not extended
          res.error_code = btlv_pkg::ERR_TAG_TOO_LONG;
          st_nxt.phase   = buffer_end ? btlv_pkg::PH_TAG_FIRST : btlv_pkg::PH_ABSORB;
        end else begin
          st_nxt.tag_acc = {st.tag_acc[23:0], data_byte};
          st_nxt.tag_cnt = st.tag_cnt + 3'd1;
          if (data_byte[7]) begin
            if (buffer_end) begin
              res.error_code = btlv_pkg::ERR_TAG_TRUNC;
              st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
            end
          end else begin
            st_nxt.phase = btlv_pkg::PH_LEN_FIRST;
            if (buffer_end) begin
              res.error_code = btlv_pkg::ERR_LEN_MISSING;
              st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
            end
          end
        end
      end
      btlv_pkg::PH_LEN_FIRST: begin
        res.byte_kind = btlv_pkg::KIND_LEN;
        if (data_byte[7] && !single_byte_length) begin
          if (n_len > 7'(MAX_LENGTH_BYTES)) begin
            res.error_code = btlv_pkg::ERR_LEN_TOO_MANY;
            st_nxt.phase   = buffer_end ? btlv_pkg::PH_TAG_FIRST : btlv_pkg::PH_ABSORB;
          end else if (n_len == 7'd0) begin
            do_fin = 1'b1;
          end else begin
            st_nxt.len_acc  = '0;
            st_nxt.len_left = n_len[2:0];
            st_nxt.phase    = btlv_pkg::PH_LEN_MORE;
            if (buffer_end) begin
              res.error_code = btlv_pkg::ERR_LEN_TRUNC;
              st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
            end
          end
        end else begin
          do_fin  = 1'b1;
          fin_len = {24'd0, data_byte};
        end
      end
      btlv_pkg::PH_LEN_MORE: begin
        res.byte_kind   = btlv_pkg::KIND_LEN;
        st_nxt.len_acc  = len_shift;
        st_nxt.len_left = len_left_dec;
        if (len_left_dec == 3'd0) begin
          do_fin  = 1'b1;
          fin_len = len_shift;
        end else if (buffer_end) begin
          res.error_code = btlv_pkg::ERR_LEN_TRUNC;
          st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
        end
      end
      btlv_pkg::PH_VALUE: begin
        res.byte_kind   = btlv_pkg::KIND_VALUE;
        st_nxt.val_left = val_dec;
        if (val_dec == 32'd0) begin
          res.value_last = 1'b1;
          st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
        end else if (buffer_end) begin
          res.error_code = btlv_pkg::ERR_VALUE_TRUNC;
          st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
        end
      end
      default: begin
        res.byte_kind = btlv_pkg::KIND_DROP;
        st_nxt.phase  = buffer_end ? btlv_pkg::PH_TAG_FIRST : btlv_pkg::PH_ABSORB;
      end
    endcase

    // header complete on this byte
    if (do_fin) begin
      res.header_done  = 1'b1;
      res.tag_value    = st.tag_acc;
      res.length_value = fin_len;
      if (fin_len == 32'd0) begin
        res.value_last = 1'b1;
        st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
      end else begin
        st_nxt.val_left = fin_len;
        st_nxt.phase    = btlv_pkg::PH_VALUE;
        if (buffer_end) begin
          res.error_code = btlv_pkg::ERR_VALUE_TRUNC;
          st_nxt.phase   = btlv_pkg::PH_TAG_FIRST;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/btlv_out_stage.sv
`default_nettype none

module btlv_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  btlv_pkg::result_t res,
  output logic              space,
  btlv_out_if.source        out_chan
);

  logic              valid_r;
  logic              valid_nxt;
  btlv_pkg::result_t res_r;

  // register frees up when empty or being drained this cycle
  assign space     = !valid_r || out_chan.ready;
  assign valid_nxt = load || (valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.byte_kind    = res_r.byte_kind;
  assign out_chan.out_byte     = res_r.out_byte;
  assign out_chan.header_done  = res_r.header_done;
  assign out_chan.tag_value    = res_r.tag_value;
  assign out_chan.length_value = res_r.length_value;
  assign out_chan.value_last   = res_r.value_last;
  assign out_chan.error_code   = res_r.error_code;

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TAG_BYTES    = 4;
  localparam int MAX_LENGTH_BYTES = 4;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  btlv_in_if  in_if ();
  btlv_out_if out_if ();
  btlv_cfg_if cfg_if ();

  ber_tlv_stream_decoder_core #(
    .MAX_TAG_BYTES    (MAX_TAG_BYTES),
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // shadow copy of the decoder state, kept in step with accepted items
  btlv_pkg::phase_t dec_phase;
  logic [31:0] tag_acc;
  logic [2:0]  tag_cnt;
  logic [31:0] len_acc;
  logic [2:0]  len_left;
  logic [31:0] val_left;
  logic        short_len_only;

  // decoded results still owed by the block, oldest first
  btlv_pkg::result_t pending_decodes[$];
  logic [7:0]  frame_bytes[$];

  int mismatch_count = 0;
  int sent_count     = 0;
  int tx_idle_pct    = 16;
  int rx_idle_pct    = 67;

  // error byte: carries the code, then absorb unless it is the buffer end
  function automatic void flag_error(inout btlv_pkg::result_t r,
                                     input btlv_pkg::error_code_t code,
                                     input logic at_end);
    r.error_code = code;
    if (at_end) begin
      dec_phase = btlv_pkg::PH_TAG_FIRST;
    end else begin
      dec_phase = btlv_pkg::PH_ABSORB;
    end
  endfunction

  // tag and length complete on this byte
  function automatic void complete_header(inout btlv_pkg::result_t r,
                                          input logic [31:0] len,
                                          input logic at_end);
    r.header_done  = 1'b1;
    r.tag_value    = tag_acc;
    r.length_value = len;
    if (len == 32'd0) begin
      // zero length: the header byte is also the last of the item
      r.value_last = 1'b1;
      dec_phase    = btlv_pkg::PH_TAG_FIRST;
    end else begin
      val_left  = len;
      dec_phase = btlv_pkg::PH_VALUE;
      if (at_end) flag_error(r, btlv_pkg::ERR_VALUE_TRUNC, 1'b1);
    end
  endfunction

  // works out the result of one buffer byte and advances the shadow state
  function automatic btlv_pkg::result_t decode_byte(input logic [7:0] b,
                                                    input logic at_end);
    btlv_pkg::result_t r;
    logic [6:0] count;
    r            = '0;
    r.byte_kind  = btlv_pkg::KIND_DROP;
    r.out_byte   = b;
    r.error_code = btlv_pkg::ERR_NONE;
    count        = b[6:0];
    case (dec_phase)
      btlv_pkg::PH_TAG_FIRST: begin
        r.byte_kind = btlv_pkg::KIND_TAG;
        tag_acc     = {24'd0, b};
        tag_cnt     = 3'd1;
        if (b[4:0] == btlv_pkg::TAG_MORE_MASK) begin
          dec_phase = btlv_pkg::PH_TAG_MORE;
          if (at_end) flag_error(r, btlv_pkg::ERR_TAG_TRUNC, 1'b1);
        end else begin
          dec_phase = btlv_pkg::PH_LEN_FIRST;
          if (at_end) flag_error(r, btlv_pkg::ERR_LEN_MISSING, 1'b1);
        end
      end
      btlv_pkg::PH_TAG_MORE: begin
        r.byte_kind = btlv_pkg::KIND_TAG;
        if (int'(tag_cnt) >= MAX_TAG_BYTES) begin
          // byte beyond the tag limit is not folded into the tag
          flag_error(r, btlv_pkg::ERR_TAG_TOO_LONG, at_end);
        end else begin
          tag_acc = {tag_acc[23:0], b};
          tag_cnt = tag_cnt + 3'd1;
          if (b[7]) begin
            if (at_end) flag_error(r, btlv_pkg::ERR_TAG_TRUNC, 1'b1);
          end else begin
            dec_phase = btlv_pkg::PH_LEN_FIRST;
            if (at_end) flag_error(r, btlv_pkg::ERR_LEN_MISSING, 1'b1);
          end
        end
      end
      btlv_pkg::PH_LEN_FIRST: begin
        r.byte_kind = btlv_pkg::KIND_LEN;
        if (b[7] && !short_len_only) begin
          if (int'(count) > MAX_LENGTH_BYTES) begin
            flag_error(r, btlv_pkg::ERR_LEN_TOO_MANY, at_end);
          end else if (count == 7'd0) begin
            complete_header(r, 32'd0, at_end);
          end else begin
            len_acc   = 32'd0;
            len_left  = count[2:0];
            dec_phase = btlv_pkg::PH_LEN_MORE;
            if (at_end) flag_error(r, btlv_pkg::ERR_LEN_TRUNC, 1'b1);
          end
        end else begin
          // short form, or forced short form even with bit 7 set
          complete_header(r, {24'd0, b}, at_end);
        end
      end
      btlv_pkg::PH_LEN_MORE: begin
        r.byte_kind = btlv_pkg::KIND_LEN;
        len_acc     = {len_acc[23:0], b};
        len_left    = len_left - 3'd1;
        if (len_left == 3'd0) begin
          complete_header(r, len_acc, at_end);
        end else if (at_end) begin
          flag_error(r, btlv_pkg::ERR_LEN_TRUNC, 1'b1);
        end
      end
      btlv_pkg::PH_VALUE: begin
        r.byte_kind = btlv_pkg::KIND_VALUE;
        val_left    = val_left - 32'd1;
        if (val_left == 32'd0) begin
          r.value_last = 1'b1;
          dec_phase    = btlv_pkg::PH_TAG_FIRST;
        end else if (at_end) begin
          // overrun only becomes visible at the buffer end
          flag_error(r, btlv_pkg::ERR_VALUE_TRUNC, 1'b1);
        end
      end
      default: begin
        // absorbing after an error until the buffer end
        r.byte_kind = btlv_pkg::KIND_DROP;
        if (at_end) begin
          dec_phase = btlv_pkg::PH_TAG_FIRST;
        end else begin
          dec_phase = btlv_pkg::PH_ABSORB;
        end
      end
    endcase
    return r;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    btlv_pkg::result_t want;
    btlv_pkg::result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.byte_kind    = btlv_pkg::byte_kind_t'(out_if.byte_kind);
      got.out_byte     = out_if.out_byte;
      got.header_done  = out_if.header_done;
      got.tag_value    = out_if.tag_value;
      got.length_value = out_if.length_value;
      got.value_last   = out_if.value_last;
      got.error_code   = btlv_pkg::error_code_t'(out_if.error_code);
      if (pending_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected, byte %h", $realtime, got.out_byte);
      end else begin
        want = pending_decodes.pop_front();
        if (got.byte_kind !== want.byte_kind || got.out_byte !== want.out_byte ||
            got.header_done !== want.header_done || got.tag_value !== want.tag_value ||
            got.length_value !== want.length_value ||
            got.value_last !== want.value_last || got.error_code !== want.error_code) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected kind %0d byte %h hdr %b tag %h len %h last %b err %0d",
                     $realtime, want.byte_kind, want.out_byte, want.header_done,
                     want.tag_value, want.length_value, want.value_last, want.error_code);
            $display("%0t: actual   kind %0d byte %h hdr %b tag %h len %h last %b err %0d",
                     $realtime, got.byte_kind, got.out_byte, got.header_done,
                     got.tag_value, got.length_value, got.value_last, got.error_code);
          end
        end
      end
    end
  end

  // one buffer byte; valid stays high on return so back-to-back items chain
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.buffer_end <= last;
    do @(posedge clk); while (!in_if.ready);
    // accepted at this edge: predict now so the state follows stream order
    pending_decodes.push_back(decode_byte(b, last));
    sent_count++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_item(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // hold the sender off until every owed result has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_decodes.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(input logic short_only);
    wait_drained();
    cfg_if.valid              <= 1'b1;
    cfg_if.single_byte_length <= short_only;
    do @(posedge clk); while (!cfg_if.ready);
    short_len_only = short_only;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // appends one random tlv to the frame; 1 when the frame must end here
  function automatic bit append_tlv();
    int          n;
    int          nb;
    int          pick;
    logic [7:0]  b;
    logic [31:0] len;
    bit          closed;
    closed = 1'b0;
    // tag: mostly one byte, some multi-byte, a few over the limit
    pick = int'($urandom_range(99));
    if (pick < 55) n = 1;
    else if (pick < 95) n = int'($urandom_range(4, 2));
    else n = MAX_TAG_BYTES + 1;
    if (n == 1) begin
      do b = 8'($urandom_range(255)); while (b[4:0] == btlv_pkg::TAG_MORE_MASK);
      frame_bytes.push_back(b);
    end else begin
      b      = 8'($urandom_range(255));
      b[4:0] = btlv_pkg::TAG_MORE_MASK;
      frame_bytes.push_back(b);
      for (int i = 1; i < n; i++) begin
        b    = 8'($urandom_range(255));
        b[7] = (i < n - 1);
        frame_bytes.push_back(b);
      end
    end
    // length field
    pick = int'($urandom_range(99));
    if (short_len_only) begin
      if (pick < 10) len = 32'($urandom_range(255));
      else len = 32'($urandom_range(6));
      frame_bytes.push_back(len[7:0]);
    end else if (pick < 45) begin
      len = 32'($urandom_range(6));
      frame_bytes.push_back(len[7:0]);
    end else if (pick < 55) begin
      len = 32'($urandom_range(127));
      frame_bytes.push_back(len[7:0]);
    end else if (pick < 62) begin
      len = 32'd0;
      frame_bytes.push_back(8'h80);
    end else if (pick < 97) begin
      // long form, small values with leading zeros or full random width
      nb = int'($urandom_range(MAX_LENGTH_BYTES, 1));
      if (pick < 90) len = 32'($urandom_range(20));
      else len = $urandom;
      if (nb < 4) len = len & ((32'd1 << (8 * nb)) - 32'd1);
      frame_bytes.push_back({1'b1, 7'(nb)});
      for (int i = nb - 1; i >= 0; i--) frame_bytes.push_back(len[8*i +: 8]);
    end else begin
      // count beyond the limit, rest of the frame gets absorbed
      len = 32'd0;
      frame_bytes.push_back({1'b1, 7'($urandom_range(127, MAX_LENGTH_BYTES + 1))});
    end
    // value bytes; huge lengths are cut short by the buffer end
    if (len > 32'd255) begin
      nb     = int'($urandom_range(10));
      closed = 1'b1;
    end else begin
      nb = int'(len);
    end
    for (int i = 0; i < nb; i++) frame_bytes.push_back(8'($urandom_range(255)));
    return closed;
  endfunction

  task automatic test_simple_items();
    // multi-byte tag with zero long-form length, then extreme value bytes
    frame_bytes = '{8'h9F, 8'h81, 8'h02, 8'h80, 8'h5A, 8'h02, 8'h00, 8'hFF};
    send_frame();
  endtask

  task automatic test_tag_limits();
    // fifth tag byte over the limit, and it is the buffer end too
    frame_bytes = '{8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'h80};
    send_frame();
    // buffer ends inside the tag
    frame_bytes = '{8'h1F};
    send_frame();
  endtask

  task automatic test_long_lengths();
    // four length bytes
    frame_bytes = '{8'h01, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAB};
    send_frame();
    // too many length bytes, then absorbed until buffer end
    frame_bytes = '{8'h02, 8'hFF, 8'h00};
    send_frame();
  endtask

  task automatic test_truncations();
    // length missing after a complete tag
    frame_bytes = '{8'h30};
    send_frame();
    // inside long-form length bytes
    frame_bytes = '{8'h03, 8'h82, 8'h01};
    send_frame();
    // on the long-form count byte
    frame_bytes = '{8'h05, 8'h81};
    send_frame();
    // header completes with nonzero length right at the end
    frame_bytes = '{8'h06, 8'h01};
    send_frame();
  endtask

  task automatic test_forced_short_length();
    write_config(1'b1);
    // 0x85 read as a plain length of 133, truncated on a value byte
    frame_bytes = '{8'h07, 8'h85, 8'hAA};
    send_frame();
    write_config(1'b0);
  endtask

  task automatic test_random_traffic(input int items, input int tx_pct, input int rx_pct);
    int stop_at;
    int buffers;
    int k;
    int pick;
    int cut;
    bit closed;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = sent_count + items;
    buffers     = 0;
    while (sent_count < stop_at) begin
      // retune the length mode now and then, with the block idle
      if (buffers % 20 == 19) write_config(1'($urandom_range(1)));
      frame_bytes.delete();
      pick = int'($urandom_range(99));
      if (pick < 8) begin
        // raw noise
        repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom_range(255)));
      end else begin
        k      = int'($urandom_range(4, 1));
        closed = 1'b0;
        while (k > 0 && !closed) begin
          closed = append_tlv();
          k--;
        end
        if (pick < 22) begin
          // broken sequence: end the buffer at a random byte
          cut = int'($urandom_range(frame_bytes.size(), 1));
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
      end
      send_frame();
      buffers++;
    end
  endtask

  initial begin
    in_if.valid               <= 1'b0;
    in_if.data_byte           <= 8'd0;
    in_if.buffer_end          <= 1'b0;
    cfg_if.valid              <= 1'b0;
    cfg_if.single_byte_length <= 1'b0;
    // shadow state as after reset
    dec_phase      = btlv_pkg::PH_TAG_FIRST;
    tag_acc        = 32'd0;
    tag_cnt        = 3'd0;
    len_acc        = 32'd0;
    len_left       = 3'd0;
    val_left       = 32'd0;
    short_len_only = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_config(1'b0);
    test_simple_items();
    test_tag_limits();
    test_long_lengths();
    test_truncations();
    test_forced_short_length();
    test_random_traffic(650, 16, 67);
    test_random_traffic(650, 67, 16);
    test_random_traffic(650, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_decodes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### ber_tlv_stream_decoder_core.f
rtl/core/btlv_pkg.sv
rtl/core/btlv_if.sv
rtl/core/btlv_step.sv
rtl/core/btlv_out_stage.sv
rtl/core/ber_tlv_stream_decoder_core.sv
sim/tb_top.sv
